@@ design/eaq_pkg.sv @@
// Shared types, constants and the arctangent table for the Euler-to-quaternion block.
`default_nettype none
package eaq_pkg;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF = 15;
   localparam int CORDIC_STEPS = 30;
   localparam int WORK_W = 34;
   localparam logic signed [WORK_W-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef logic [$clog2(CORDIC_STEPS)-1:0] step_idx_type;

   typedef struct packed {
      logic signed [ANGLE_BITS_DEF-1:0] pitch_angle;
      logic signed [ANGLE_BITS_DEF-1:0] yaw_angle;
      logic signed [ANGLE_BITS_DEF-1:0] roll_angle;
   } req_type;

   typedef struct packed {
      logic signed [FRAC_BITS_DEF:0] quat_w;
      logic signed [FRAC_BITS_DEF:0] quat_x;
      logic signed [FRAC_BITS_DEF:0] quat_y;
      logic signed [FRAC_BITS_DEF:0] quat_z;
   } rsp_type;

   // arctangent of 2^-i, 2^32 units per turn
   function automatic logic signed [WORK_W-1:0] atan_turn(input step_idx_type i);
      logic signed [WORK_W-1:0] v;
      case (i)
         5'd0:  v = 34'sh020000000;
         5'd1:  v = 34'sh012E4051E;
         5'd2:  v = 34'sh009FB385B;
         5'd3:  v = 34'sh0051111D4;
         5'd4:  v = 34'sh0028B0D43;
         5'd5:  v = 34'sh00145D7E1;
         5'd6:  v = 34'sh000A2F61E;
         5'd7:  v = 34'sh000517C55;
         5'd8:  v = 34'sh00028BE53;
         5'd9:  v = 34'sh000145F2F;
         5'd10: v = 34'sh0000A2F98;
         5'd11: v = 34'sh0000517CC;
         5'd12: v = 34'sh000028BE6;
         5'd13: v = 34'sh0000145F3;
         5'd14: v = 34'sh00000A2FA;
         5'd15: v = 34'sh00000517D;
         5'd16: v = 34'sh0000028BE;
         5'd17: v = 34'sh00000145F;
         5'd18: v = 34'sh000000A30;
         5'd19: v = 34'sh000000518;
         5'd20: v = 34'sh00000028C;
         5'd21: v = 34'sh000000146;
         5'd22: v = 34'sh0000000A3;
         5'd23: v = 34'sh000000051;
         5'd24: v = 34'sh000000029;
         5'd25: v = 34'sh000000014;
         5'd26: v = 34'sh00000000A;
         5'd27: v = 34'sh000000005;
         5'd28: v = 34'sh000000003;
         5'd29: v = 34'sh000000001;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

@@ design/eaq_cordic_cell.sv @@
// One CORDIC rotation cell: three angles rotated by one micro-step, registered.
`default_nettype none
module eaq_cordic_cell
   import eaq_pkg::*;
#(
   parameter int STEP = 0
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     advance,
   input  wire                     valid_in,
   input  wire logic signed [WORK_W-1:0] x_in [3],
   input  wire logic signed [WORK_W-1:0] y_in [3],
   input  wire logic signed [WORK_W-1:0] z_in [3],
   output logic                    valid_out,
   output logic signed [WORK_W-1:0] x_out [3],
   output logic signed [WORK_W-1:0] y_out [3],
   output logic signed [WORK_W-1:0] z_out [3]
);
   localparam logic signed [WORK_W-1:0] ATAN = atan_turn(step_idx_type'(STEP));

   logic                     valid_ff;
   logic signed [WORK_W-1:0] x_ff [3];
   logic signed [WORK_W-1:0] y_ff [3];
   logic signed [WORK_W-1:0] z_ff [3];
   logic signed [WORK_W-1:0] x_nx [3];
   logic signed [WORK_W-1:0] y_nx [3];
   logic signed [WORK_W-1:0] z_nx [3];

   // rotate toward zero residual angle
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (!z_in[a][WORK_W-1]) begin
            x_nx[a] = x_in[a] - (y_in[a] >>> STEP);
            y_nx[a] = y_in[a] + (x_in[a] >>> STEP);
            z_nx[a] = z_in[a] - ATAN;
         end else begin
            x_nx[a] = x_in[a] + (y_in[a] >>> STEP);
            y_nx[a] = y_in[a] - (x_in[a] >>> STEP);
            z_nx[a] = z_in[a] + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= x_nx;
         y_ff <= y_nx;
         z_ff <= z_nx;
      end
   end

   assign valid_out = valid_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
endmodule
`default_nettype wire

@@ design/eaq_combine.sv @@
// Triple products and output rounding over three registered stages.
`default_nettype none
module eaq_combine
   import eaq_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     advance,
   input  wire                     valid_in,
   input  wire logic signed [WORK_W-1:0] sn_in [3],
   input  wire logic signed [WORK_W-1:0] cs_in [3],
   output logic                    valid_out,
   output logic signed [FRAC_BITS:0] q_out [4]
);
   localparam int SH = 60 - FRAC_BITS;
   localparam int PW = 2 * WORK_W;
   localparam logic signed [PW-1:0] HALF_P = PW'(64'sd1 <<< 29);
   localparam logic signed [PW:0] HALF_S = (PW+1)'(64'sd1 <<< (SH - 1));
   localparam logic signed [PW:0] HI = (PW+1)'((64'sd1 <<< FRAC_BITS) - 1);
   localparam logic signed [PW:0] LO = -(PW+1)'(64'sd1 <<< FRAC_BITS);

   // index 0 pitch, 1 yaw, 2 roll
   logic [2:0]               valid_ff;
   logic signed [WORK_W-1:0] p_ff [4];     // SY*SP, CY*CP, SY*CP, CY*SP
   logic signed [WORK_W-1:0] sr_ff, cr_ff;
   logic signed [PW-1:0]     t_ff [8];
   logic signed [FRAC_BITS:0] q_ff [4];
   logic signed [PW-1:0]     m_in [4];
   logic signed [WORK_W-1:0] p_in [4];
   logic signed [PW:0]       s_in [4];
   logic signed [PW:0]       r_in [4];
   logic signed [FRAC_BITS:0] q_in [4];

   // pair products, rounded back to Q.30
   always_comb begin
      m_in[0] = PW'(sn_in[1]) * PW'(sn_in[0]);
      m_in[1] = PW'(cs_in[1]) * PW'(cs_in[0]);
      m_in[2] = PW'(sn_in[1]) * PW'(cs_in[0]);
      m_in[3] = PW'(cs_in[1]) * PW'(sn_in[0]);
      for (int k = 0; k < 4; k++) begin
         p_in[k] = WORK_W'((m_in[k] + HALF_P) >>> 30);
      end
   end

   // sum, round half up and saturate
   always_comb begin
      s_in[0] = (PW+1)'(t_ff[0]) + (PW+1)'(t_ff[1]);
      s_in[1] = (PW+1)'(t_ff[2]) - (PW+1)'(t_ff[3]);
      s_in[2] = (PW+1)'(t_ff[4]) + (PW+1)'(t_ff[5]);
      s_in[3] = (PW+1)'(t_ff[6]) - (PW+1)'(t_ff[7]);
      for (int k = 0; k < 4; k++) begin
         r_in[k] = (s_in[k] + HALF_S) >>> SH;
         if (r_in[k] > HI) begin
            q_in[k] = (FRAC_BITS+1)'(HI);
         end else if (r_in[k] < LO) begin
            q_in[k] = (FRAC_BITS+1)'(LO);
         end else begin
            q_in[k] = (FRAC_BITS+1)'(r_in[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[1:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff  <= p_in;
         sr_ff <= sn_in[2];
         cr_ff <= cs_in[2];
         t_ff[0] <= PW'(p_ff[0]) * PW'(sr_ff);
         t_ff[1] <= PW'(p_ff[1]) * PW'(cr_ff);
         t_ff[2] <= PW'(p_ff[1]) * PW'(sr_ff);
         t_ff[3] <= PW'(p_ff[0]) * PW'(cr_ff);
         t_ff[4] <= PW'(p_ff[2]) * PW'(sr_ff);
         t_ff[5] <= PW'(p_ff[3]) * PW'(cr_ff);
         t_ff[6] <= PW'(p_ff[2]) * PW'(cr_ff);
         t_ff[7] <= PW'(p_ff[3]) * PW'(sr_ff);
         q_ff <= q_in;
      end
   end

   assign valid_out = valid_ff[2];
   assign q_out = q_ff;
endmodule
`default_nettype wire

@@ design/euler_angles_to_quaternion.sv @@
// Top level: Euler angles to Q1.15 quaternion through a chain of CORDIC cells.
`default_nettype none
// Takes pitch, yaw and roll as binary angles and returns the unit quaternion
// w, x, y, z in Q1.FRAC_BITS, saturated to the range from minus one to just
// below plus one. One item is accepted every cycle while the output is not
// stalled; its result passes through one entry register loaded at the edge
// that accepts it, then thirty CORDIC cells and three product and rounding
// stages. The whole pipeline moves only when the output register is free or
// being drained, so a stall on the result side holds every item in place.
module euler_angles_to_quaternion
   import eaq_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  wire req_type req_data,
   output logic    rsp_valid,
   input  wire     rsp_ready,
   output rsp_type rsp_data
);
   logic                     advance;
   logic                     in_valid_ff;
   logic signed [WORK_W-1:0] z0_ff [3];
   logic signed [WORK_W-1:0] z0_in [3];
   logic signed [WORK_W-1:0] x0 [3];
   logic signed [WORK_W-1:0] y0 [3];
   logic                     vc [CORDIC_STEPS+1];
   logic signed [WORK_W-1:0] xc [CORDIC_STEPS+1][3];
   logic signed [WORK_W-1:0] yc [CORDIC_STEPS+1][3];
   logic signed [WORK_W-1:0] zc [CORDIC_STEPS+1][3];
   logic                     cmb_valid;
   logic signed [FRAC_BITS:0] q [4];
   logic signed [ANGLE_BITS-1:0] ang [3];

   // move when the output register is empty or being taken
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign ang[0] = ANGLE_BITS'(req_data.pitch_angle);
   assign ang[1] = ANGLE_BITS'(req_data.yaw_angle);
   assign ang[2] = ANGLE_BITS'(req_data.roll_angle);

   // halve each angle and scale it to a 2^32 turn
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         z0_in[a] = WORK_W'(ang[a] >>> 1) <<< (32 - ANGLE_BITS);
         x0[a] = CORDIC_GAIN;
         y0[a] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         z0_ff <= z0_in;
      end
   end

   assign vc[0] = in_valid_ff;
   assign xc[0] = x0;
   assign yc[0] = y0;
   assign zc[0] = z0_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      eaq_cordic_cell #(.STEP(i)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .valid_in(vc[i]), .x_in(xc[i]), .y_in(yc[i]), .z_in(zc[i]),
         .valid_out(vc[i+1]), .x_out(xc[i+1]), .y_out(yc[i+1]), .z_out(zc[i+1])
      );
   end

   eaq_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
      .clock(clock), .reset(reset), .advance(advance),
      .valid_in(vc[CORDIC_STEPS]),
      .sn_in(yc[CORDIC_STEPS]), .cs_in(xc[CORDIC_STEPS]),
      .valid_out(cmb_valid), .q_out(q)
   );

   assign rsp_valid = cmb_valid;
   assign rsp_data.quat_w = q[0];
   assign rsp_data.quat_x = q[1];
   assign rsp_data.quat_y = q[2];
   assign rsp_data.quat_z = q[3];

`ifndef SYNTHESIS
   a_ready_tracks: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready does not follow output stall");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result lost during stall");
   a_entry_valid: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> in_valid_ff)
      else $error("accepted item not captured");
`endif
endmodule
`default_nettype wire
